// ===== rtl/csum_pkg.sv =====
// Types, op codes and the saturating add shared by the CIGAR summary block.
// No dependencies.
package csum_pkg;

   localparam int unsigned OP_WIDTH    = 4;
   localparam int unsigned LEN_WIDTH   = 28;
   localparam int unsigned TOTAL_WIDTH = 32;

   localparam logic [OP_WIDTH-1:0] OP_M  = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_I  = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_D  = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_N  = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_S  = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_EQ = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_X  = 4'd8;

   typedef logic [TOTAL_WIDTH-1:0] total_type;

   typedef struct packed {
      logic                 unmapped;
      logic                 last_op;
      logic [LEN_WIDTH-1:0] op_length;
      logic [OP_WIDTH-1:0]  op_code;
   } csum_op_type;

   // field order matches the result beat, highest first
   typedef struct packed {
      total_type clip_three_prime;
      total_type clip_five_prime;
      total_type deleted_bases;
      total_type query_length;
      total_type reference_length;
   } csum_totals_type;

   function automatic total_type sat_add(input total_type acc,
                                         input logic [LEN_WIDTH-1:0] len);
      logic [TOTAL_WIDTH:0] sum;
      sum = {1'b0, acc} + {{(TOTAL_WIDTH+1-LEN_WIDTH){1'b0}}, len};
      return sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : sum[TOTAL_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/csum_accum.sv =====
// Running totals for one CIGAR record: op decode, saturating adds, result build.
// Depends on csum_pkg.
module csum_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  csum_pkg::csum_op_type    op,
   output csum_pkg::csum_totals_type result,
   output csum_pkg::csum_totals_type totals
);
   import csum_pkg::*;

   csum_totals_type totals_ff, totals_in, sum_next;
   logic            at_first_ff, at_first_in;
   logic            add_ref, add_query, add_del, add_clip;

   always_comb begin
      add_ref   = 1'b0;
      add_query = 1'b0;
      add_del   = 1'b0;
      add_clip  = 1'b0;
      case (op.op_code)
         OP_M: begin
            add_ref   = 1'b1;
            add_query = 1'b1;
         end
         OP_I:  add_query = 1'b1;
         OP_D, OP_N: begin
            add_ref = 1'b1;
            add_del = 1'b1;
         end
         OP_S: begin
            add_query = 1'b1;
            add_clip  = 1'b1;
         end
         OP_EQ, OP_X: add_query = 1'b1;
         default: ;  // H, P and unused codes add nothing
      endcase
   end

   always_comb begin
      sum_next = totals_ff;
      if (add_ref)
         sum_next.reference_length = sat_add(totals_ff.reference_length, op.op_length);
      if (add_query)
         sum_next.query_length = sat_add(totals_ff.query_length, op.op_length);
      if (add_del)
         sum_next.deleted_bases = sat_add(totals_ff.deleted_bases, op.op_length);
      if (add_clip && at_first_ff)
         sum_next.clip_five_prime = sat_add(totals_ff.clip_five_prime, op.op_length);
      if (add_clip && !at_first_ff)
         sum_next.clip_three_prime = sat_add(totals_ff.clip_three_prime, op.op_length);

      result = op.unmapped ? '0 : sum_next;

      totals_in   = totals_ff;
      at_first_in = at_first_ff;
      if (step_en) begin
         totals_in   = op.last_op ? '0 : sum_next;
         at_first_in = op.last_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         totals_ff   <= '0;
         at_first_ff <= 1'b1;
      end else begin
         totals_ff   <= totals_in;
         at_first_ff <= at_first_in;
      end
   end

   assign totals = totals_ff;

endmodule

// ===== rtl/cigar_alignment_summary.sv =====
// Top level of the CIGAR alignment summary: input register, accumulator, result register.
// Depends on csum_pkg and csum_accum.
//
//   channel  | dir | payload
//   req_     | in  | tdata {op_length, op_code}, tlast last_op, tuser unmapped
//   rsp_     | out | tdata {clip_3', clip_5', deleted, query_len, ref_len}
//
// One op per cycle unless a last op waits for a busy result register; each op is held in
// the input register, and the record's totals are then registered into the result register.
// Reset clears the totals and both valid flags.
// A stalled result holds back only a last op; other ops keep flowing.
module cigar_alignment_summary (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [3:0] op_code, [31:4] op_length
   input  logic         req_tlast,   // last_op
   input  logic         req_tuser,   // unmapped
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata    // reference_length, query_length, deleted_bases,
                                     // clip_five_prime, clip_three_prime
);
   import csum_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   csum_op_type     s1_op_ff, s1_op_in;
   logic            rsp_valid_ff, rsp_valid_in;
   csum_totals_type rsp_data_ff, rsp_data_in;
   csum_totals_type result, totals;
   logic            out_free, s1_advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!s1_op_ff.last_op || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;

   csum_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_advance),
      .op      (s1_op_ff),
      .result  (result),
      .totals  (totals)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_op_in    = '{unmapped: req_tuser, last_op: req_tlast,
                         op_length: req_tdata[31:4], op_code: req_tdata[3:0]};
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance && s1_op_ff.last_op) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_op_ff    <= s1_op_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // totals restart from zero after a record closes
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_op_ff.last_op |=> totals == '0)
      else $error("totals not cleared after last op");

   // an unmapped record reports all zeros
   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_op_ff.last_op && s1_op_ff.unmapped |=> rsp_tvalid && rsp_tdata == '0)
      else $error("unmapped record gave nonzero totals");

   // reference length never shrinks inside a record
   a_ref_monotonic: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_op_ff.last_op
         |=> totals.reference_length >= $past(totals.reference_length))
      else $error("reference total decreased mid-record");

   // a stall on the input side needs a held last op and a stalled result
   a_stall_needs_op: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s1_op_ff.last_op && rsp_tvalid && !rsp_tready)
      else $error("input stalled without cause");

endmodule

// ===== tb/cigar_alignment_summary_tb.sv =====
// Self-checking testbench for cigar_alignment_summary: drives CIGAR op beats, tallies the
// expected per-record totals alongside the block and compares every result beat.
// Depends on csum_pkg and the cigar_alignment_summary RTL.
module cigar_alignment_summary_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csum_pkg::*;

   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_WAIT  = 8;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};
   localparam logic [OP_WIDTH-1:0]  OP_H = 4'd5;
   localparam logic [OP_WIDTH-1:0]  OP_P = 4'd6;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata  = '0;   // [3:0] op_code, [31:4] op_length
   logic         req_tlast  = 1'b0; // last_op
   logic         req_tuser  = 1'b0; // unmapped
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;         // reference_length, query_length, deleted_bases,
                                    // clip_five_prime, clip_three_prime

   cigar_alignment_summary dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // running totals of the record in flight, as the block should hold them
   total_type tally_ref   = '0;
   total_type tally_query = '0;
   total_type tally_del   = '0;
   total_type tally_head  = '0;
   total_type tally_tail  = '0;
   bit        tally_opening = 1'b1;

   csum_totals_type expected_totals[$];
   int unsigned     error_count = 0;
   int unsigned     tx_max_gap  = 10;
   int unsigned     rx_max_gap  = 10;
   int unsigned     hold_requests = 0;
   int unsigned     hold_served   = 0;
   int unsigned     hold_left     = 0;
   int unsigned     rx_wait       = 0;
   int unsigned     idle_cycles   = 0;

   function automatic total_type clamp_add(total_type acc, logic [LEN_WIDTH-1:0] len);
      total_type room;
      room = 32'hFFFF_FFFF - acc;
      return (total_type'(len) > room) ? 32'hFFFF_FFFF : acc + total_type'(len);
   endfunction

   // Folds one op into the tally; returns 1 with the record's totals on a last op.
   function automatic bit tally_op(logic [OP_WIDTH-1:0] op, logic [LEN_WIDTH-1:0] len,
                                   logic last, logic unm, output csum_totals_type res);
      res = '0;
      if (op == OP_M || op == OP_D || op == OP_N)
         tally_ref = clamp_add(tally_ref, len);
      if (op == OP_M || op == OP_I || op == OP_S || op == OP_EQ || op == OP_X)
         tally_query = clamp_add(tally_query, len);
      if (op == OP_D || op == OP_N)
         tally_del = clamp_add(tally_del, len);
      if (op == OP_S) begin
         if (tally_opening)
            tally_head = clamp_add(tally_head, len);
         else
            tally_tail = clamp_add(tally_tail, len);
      end
      tally_opening = 1'b0;
      if (!last)
         return 1'b0;
      if (!unm) begin
         res.reference_length = tally_ref;
         res.query_length     = tally_query;
         res.deleted_bases    = tally_del;
         res.clip_five_prime  = tally_head;
         res.clip_three_prime = tally_tail;
      end
      tally_ref     = '0;
      tally_query   = '0;
      tally_del     = '0;
      tally_head    = '0;
      tally_tail    = '0;
      tally_opening = 1'b1;
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, total_type want, total_type got);
      $display("%0t ns: MISMATCH %s expected %0d got %0d", $time, what, want, got);
      error_count++;
   endtask

   // Offers one op beat after a random gap and books the expected totals on acceptance.
   task automatic send_op(logic [OP_WIDTH-1:0] op, logic [LEN_WIDTH-1:0] len,
                          logic last, logic unm);
      int unsigned     gap;
      csum_totals_type res;
      gap = $urandom_range(0, tx_max_gap);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, op};
      req_tlast  <= last;
      req_tuser  <= unm;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (tally_op(op, len, last, unm, res))
         expected_totals.insert(expected_totals.size(), res);
   endtask

   function automatic logic [LEN_WIDTH-1:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return LEN_MAX;
         2, 3:    return LEN_WIDTH'($urandom);
         default: return LEN_WIDTH'($urandom_range(1, 500));
      endcase
   endfunction

   function automatic logic [OP_WIDTH-1:0] pick_op();
      if ($urandom_range(0, 4) == 0)
         return OP_WIDTH'($urandom_range(0, 15));
      return OP_WIDTH'($urandom_range(0, 8));
   endfunction

   // Each op code as a one-op record; mixed, hard-clip, unmapped records; zero, max lengths.
   task automatic test_directed();
      for (int op = 0; op < 16; op++)
         send_op(OP_WIDTH'(op), LEN_WIDTH'(op * 3 + 1), 1'b1, 1'b0);
      send_op(OP_S, LEN_WIDTH'(12), 1'b0, 1'b0);
      send_op(OP_M, LEN_MAX, 1'b0, 1'b1);
      send_op(OP_I, LEN_WIDTH'(0), 1'b0, 1'b0);
      send_op(OP_D, LEN_WIDTH'(7), 1'b0, 1'b0);
      send_op(OP_N, LEN_WIDTH'(100), 1'b0, 1'b0);
      send_op(OP_EQ, LEN_WIDTH'(5), 1'b0, 1'b0);
      send_op(OP_X, LEN_WIDTH'(3), 1'b0, 1'b0);
      send_op(OP_S, LEN_WIDTH'(9), 1'b1, 1'b0);
      // hard clip opens the record, so the soft clip after it is 3'
      send_op(OP_H, LEN_WIDTH'(40), 1'b0, 1'b0);
      send_op(OP_S, LEN_WIDTH'(20), 1'b1, 1'b0);
      // unmapped record, flag only on the last beat
      send_op(OP_M, LEN_WIDTH'(50), 1'b0, 1'b0);
      send_op(OP_P, LEN_MAX, 1'b1, 1'b1);
   endtask

   // Drives every total but clip_five_prime past 2^32-1.
   task automatic test_saturation();
      send_op(OP_S, LEN_MAX, 1'b0, 1'b0);
      for (int k = 0; k < 18; k++)
         send_op((k % 2) ? OP_N : OP_D, LEN_MAX, 1'b0, 1'b0);
      for (int k = 0; k < 18; k++)
         send_op(OP_S, LEN_MAX, 1'b0, 1'b0);
      send_op(OP_M, LEN_MAX, 1'b1, 1'b0);
   endtask

   task automatic test_random(int unsigned item_goal);
      int unsigned sent;
      int unsigned rec_len;
      int unsigned gap_choice;
      sent = 0;
      while (sent < item_goal) begin
         if (sent % 60 < 8) begin
            gap_choice  = $urandom_range(0, 2);
            tx_max_gap  = (gap_choice == 0) ? 0 : (gap_choice == 1) ? 3 : 10;
            rx_max_gap <= (gap_choice == 2) ? 0 : $urandom_range(0, 1) * 10;
         end
         rec_len = ($urandom_range(0, 19) == 0) ? 20 : $urandom_range(1, 8);
         for (int k = 1; k <= rec_len; k++)
            send_op(pick_op(), pick_length(), k == rec_len,
                    ($urandom_range(0, 4) == 0));
         sent += rec_len;
      end
   endtask

   // Receiver holds off while one-op records keep coming back to back.
   task automatic test_backpressure();
      tx_max_gap = 0;
      hold_requests <= hold_requests + 1;
      for (int k = 0; k < 40; k++)
         send_op(pick_op(), pick_length(), 1'b1, k[0]);
      tx_max_gap  = 10;
      rx_max_gap <= 10;
   endtask

   // result side: random stall per beat, plus a long hold when one is requested
   always @(posedge clock) begin
      int unsigned draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait    <= 0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         draw = $urandom_range(0, rx_max_gap);
         rx_wait    <= draw;
         rsp_tready <= (draw == 0);
      end else if (rx_wait != 0) begin
         rx_wait    <= rx_wait - 1;
         rsp_tready <= (rx_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      csum_totals_type want;
      logic [159:0]    want_bits;
      string           field_name[5];
      field_name = '{"reference_length", "query_length", "deleted_bases",
                     "clip_five_prime", "clip_three_prime"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_totals.size() == 0) begin
            $display("%0t ns: MISMATCH result beat with no record pending", $time);
            error_count++;
         end else begin
            want      = expected_totals.pop_front();
            want_bits = want;
            for (int k = 0; k < 5; k++)
               if (rsp_tdata[32*k +: 32] !== want_bits[32*k +: 32])
                  report_mismatch(field_name[k], want_bits[32*k +: 32],
                                  rsp_tdata[32*k +: 32]);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: timeout, no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("cigar_alignment_summary_tb: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_saturation();
      test_random(400);
      test_backpressure();
      req_tvalid <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("cigar_alignment_summary_tb: done, clean");
      else
         $display("cigar_alignment_summary_tb: done, errors");
      $finish;
   end

endmodule
